@@ design/ua_pkg.sv @@
// Shared types and constants of the up arpeggiator.
// Used by the front, back and top level files; depends on nothing else.
package ua_pkg;

    localparam int NOTE_SLOTS  = 128;
    localparam int ADDR_W      = $clog2(NOTE_SLOTS);
    localparam int COUNT_W     = $clog2(NOTE_SLOTS + 1);
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int STEP_W      = 8;
    localparam int REM_W       = STEP_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_NOTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic              func;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } t_item;

endpackage

@@ design/ua_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module ua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ua_front.sv @@
// Front end: takes command transactions, drops note events outside the table
// and queues the rest for the back end. Depends on ua_pkg.
module ua_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  ua_pkg::t_item i_item,
    output logic          o_valid,
    output ua_pkg::t_item o_item,
    input  logic          i_pop
);

    localparam int DEPTH   = ua_pkg::QUEUE_DEPTH;
    localparam int QPTR_W  = ua_pkg::QPTR_W;
    localparam int QFILL_W = ua_pkg::QFILL_W;
    localparam int REM_W   = ua_pkg::REM_W;

    ua_pkg::t_item      r_q [DEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QFILL_W-1:0] r_fill, n_fill;
    logic               w_accept;
    logic               w_keep;
    logic               w_push;
    logic               w_pop;

    assign o_busy   = (r_fill == QFILL_W'(DEPTH));
    assign o_valid  = (r_fill != '0);
    assign o_item   = r_q[r_rptr];
    assign w_accept = i_start && !o_busy;

    // A note event for a note past the table changes nothing, so it is not queued.
    assign w_keep = (i_item.func == ua_pkg::FUNC_TICK)
                 || (REM_W'(i_item.note) < REM_W'(ua_pkg::NOTE_SLOTS));
    assign w_push = w_accept && w_keep;
    assign w_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (w_push) begin
            n_wptr = (r_wptr == QPTR_W'(DEPTH - 1)) ? '0 : QPTR_W'(r_wptr + 1'b1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == QPTR_W'(DEPTH - 1)) ? '0 : QPTR_W'(r_rptr + 1'b1);
        end
        if (w_push && !w_pop) begin
            n_fill = QFILL_W'(r_fill + 1'b1);
        end else if (w_pop && !w_push) begin
            n_fill = QFILL_W'(r_fill - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= i_item;
        end
    end

endmodule

@@ design/ua_back.sv @@
// Back end: applies note events to the held-note table and runs ticks
// (note-off, step modulo, ascending scan, note-on). Depends on ua_pkg and ua_ram.
module ua_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  ua_pkg::t_item            i_item,
    output logic                     o_pop,
    output logic                     o_strobe,
    output logic [ua_pkg::NOTE_W-1:0] o_out_note,
    output logic [ua_pkg::VEL_W-1:0] o_out_velocity,
    output logic                     o_bang,
    output logic                     o_last
);

    localparam int SLOTS   = ua_pkg::NOTE_SLOTS;
    localparam int ADDR_W  = ua_pkg::ADDR_W;
    localparam int COUNT_W = ua_pkg::COUNT_W;
    localparam int NOTE_W  = ua_pkg::NOTE_W;
    localparam int VEL_W   = ua_pkg::VEL_W;
    localparam int STEP_W  = ua_pkg::STEP_W;
    localparam int REM_W   = ua_pkg::REM_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MOD  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_READ = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [SLOTS-1:0]   r_held, n_held;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_sounding_valid, n_sounding_valid;
    logic [NOTE_W-1:0]  r_sounding_note, n_sounding_note;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [COUNT_W-1:0] r_seen, n_seen;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_strobe, n_strobe;
    logic [NOTE_W-1:0]  r_note, n_note;
    logic [VEL_W-1:0]   r_vel, n_vel;
    logic               r_bang, n_bang;
    logic               r_last, n_last;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic               w_re;
    logic [VEL_W-1:0]   w_rdata;
    logic               w_hold;

    ua_ram #(
        .WIDTH (VEL_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_item.vel),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_waddr = ADDR_W'(i_item.note);
    assign w_hold  = (i_item.vel != '0);

    always_comb begin
        n_state          = r_state;
        n_held           = r_held;
        n_count          = r_count;
        n_step           = r_step;
        n_sounding_valid = r_sounding_valid;
        n_sounding_note  = r_sounding_note;
        n_rem            = r_rem;
        n_seen           = r_seen;
        n_addr           = r_addr;
        n_strobe         = 1'b0;
        n_note           = r_note;
        n_vel            = r_vel;
        n_bang           = r_bang;
        n_last           = r_last;
        o_pop            = 1'b0;
        w_we             = 1'b0;
        w_re             = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_item.func == ua_pkg::FUNC_NOTE) begin
                        // The held bit doubles as the table's valid bit, so the
                        // RAM never needs clearing.
                        w_we            = 1'b1;
                        n_held[w_waddr] = w_hold;
                        if (w_hold && !r_held[w_waddr]) begin
                            n_count = COUNT_W'(r_count + 1'b1);
                        end else if (!w_hold && r_held[w_waddr]) begin
                            n_count = COUNT_W'(r_count - 1'b1);
                        end
                    end else begin
                        if (r_sounding_valid) begin
                            n_strobe         = 1'b1;
                            n_note           = r_sounding_note;
                            n_vel            = '0;
                            n_bang           = 1'b0;
                            n_last           = (r_count == '0);
                            n_sounding_valid = 1'b0;
                        end
                        if (r_count == '0) begin
                            n_step = '0;
                        end else begin
                            n_rem   = REM_W'(r_step) + REM_W'(1);
                            n_state = ST_MOD;
                        end
                    end
                end
            end
            ST_MOD: begin
                // Modulo by repeated subtraction; the index is normally below the count, so
                // at most one subtraction is then needed.
                if (r_rem >= REM_W'(r_count)) begin
                    n_rem = r_rem - REM_W'(r_count);
                end else begin
                    n_step  = r_rem[STEP_W-1:0];
                    n_seen  = '0;
                    n_addr  = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_held[r_addr] && (REM_W'(r_seen) == r_rem)) begin
                    w_re    = 1'b1;
                    n_state = ST_READ;
                end else begin
                    if (r_held[r_addr]) begin
                        n_seen = COUNT_W'(r_seen + 1'b1);
                    end
                    n_addr = ADDR_W'(r_addr + 1'b1);
                end
            end
            ST_READ: begin
                n_strobe         = 1'b1;
                n_note           = NOTE_W'(r_addr);
                n_vel            = w_rdata;
                n_bang           = 1'b1;
                n_last           = 1'b1;
                n_sounding_valid = 1'b1;
                n_sounding_note  = NOTE_W'(r_addr);
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_held           <= '0;
            r_count          <= '0;
            r_step           <= '0;
            r_sounding_valid <= 1'b0;
            r_sounding_note  <= '0;
            r_strobe         <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_held           <= n_held;
            r_count          <= n_count;
            r_step           <= n_step;
            r_sounding_valid <= n_sounding_valid;
            r_sounding_note  <= n_sounding_note;
            r_strobe         <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_seen <= n_seen;
        r_addr <= n_addr;
        r_note <= n_note;
        r_vel  <= n_vel;
        r_bang <= n_bang;
        r_last <= n_last;
    end

    assign o_strobe       = r_strobe;
    assign o_out_note     = r_note;
    assign o_out_velocity = r_vel;
    assign o_bang         = r_bang;
    assign o_last         = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        REM_W'(r_count) <= REM_W'(SLOTS))
        else $error("held-note count exceeds the table size");

    a_scan_has_notes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count != '0))
        else $error("scan started with no held notes");

    a_read_is_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> r_held[r_addr])
        else $error("note-on read targets an entry that is not held");

    a_bang_sounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_bang) |-> (r_sounding_valid && (r_sounding_note == r_note)))
        else $error("note-on sent without recording the sounding note");

endmodule

@@ design/up_arpeggiator.sv @@
// Top level of the up arpeggiator: joins the front end queue and the back end.
// Depends on ua_pkg, ua_front and ua_back.
//
// A transaction is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. The back end applies a note event
// in its idle state. A tick sends the optional note-off as it is taken, then
// runs the step modulo (one subtraction per cycle), then scans the held-note
// bits one entry per cycle up to the selected note and then reads the table
// RAM. The ascending scan and the single read port of the table set the cost
// of a tick. Each result shows on the o_ ports for exactly one cycle with
// o_strobe high and cannot be held off. The held-note table is empty straight
// after reset with no clearing pass.
module up_arpeggiator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_func,
    input  logic [ua_pkg::NOTE_W-1:0] i_note_number,
    input  logic [ua_pkg::VEL_W-1:0]  i_note_velocity,
    output logic                      o_strobe,
    output logic [ua_pkg::NOTE_W-1:0] o_out_note,
    output logic [ua_pkg::VEL_W-1:0]  o_out_velocity,
    output logic                      o_bang,
    output logic                      o_last
);

    ua_pkg::t_item w_in_item;
    ua_pkg::t_item w_q_item;
    logic          w_q_valid;
    logic          w_pop;

    assign w_in_item.func = i_func;
    assign w_in_item.note = i_note_number;
    assign w_in_item.vel  = i_note_velocity;

    ua_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_item  (w_in_item),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    ua_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_out_note     (o_out_note),
        .o_out_velocity (o_out_velocity),
        .o_bang         (o_bang),
        .o_last         (o_last)
    );

endmodule

@@ test/arp_step_checker.sv @@
`timescale 1ns / 100ps
// Self-checking monitor for the up arpeggiator. It mirrors the held-note table, predicts
// the note-off and note-on messages of every tick, and compares them with the strobed results.
// Depends on ua_pkg for the field widths, table size and command codes.
module arp_step_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic                      i_func,
    input  logic [ua_pkg::NOTE_W-1:0] i_note_number,
    input  logic [ua_pkg::VEL_W-1:0]  i_note_velocity,
    input  logic                      i_strobe,
    input  logic [ua_pkg::NOTE_W-1:0] i_out_note,
    input  logic [ua_pkg::VEL_W-1:0]  i_out_velocity,
    input  logic                      i_bang,
    input  logic                      i_last,
    output int                        o_mismatches,
    output int                        o_pending,
    output int                        o_messages
);
    import ua_pkg::*;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic              bang;
        logic              last;
    } t_midi_msg;

    logic [VEL_W-1:0]  held_vel [NOTE_SLOTS];
    logic [STEP_W-1:0] arp_index;
    logic              note_on_active;
    logic [NOTE_W-1:0] note_on_number;
    t_midi_msg         expected_msgs [$];
    int                mismatch_count = 0;
    int                message_count = 0;

    // One tick: close the step that is sounding, then pick the held note whose
    // rank in ascending pitch order follows the previous one.
    task automatic play_tick();
        int        held_count;
        int        rank;
        int        seen;
        t_midi_msg msg;
        held_count = 0;
        for (int n = 0; n < NOTE_SLOTS; n++)
            if (held_vel[n] != '0) held_count++;
        if (note_on_active) begin
            msg = '{note_on_number, '0, 1'b0, held_count == 0};
            expected_msgs = {expected_msgs, msg};
            note_on_active = 1'b0;
        end
        if (held_count == 0) begin
            arp_index = '0;
        end else begin
            // A stale index left by released notes wraps back through the modulo.
            rank = (int'(arp_index) + 1) % held_count;
            arp_index = rank[STEP_W-1:0];
            seen = 0;
            for (int n = 0; n < NOTE_SLOTS; n++) begin
                if (held_vel[n] != '0) begin
                    if (seen == rank) begin
                        msg = '{n[NOTE_W-1:0], held_vel[n], 1'b1, 1'b1};
                        expected_msgs = {expected_msgs, msg};
                        note_on_active = 1'b1;
                        note_on_number = n[NOTE_W-1:0];
                    end
                    seen++;
                end
            end
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_midi_msg want;
        if (!i_rst_n) begin
            for (int n = 0; n < NOTE_SLOTS; n++)
                held_vel[n] = '0;
            arp_index = '0;
            note_on_active = 1'b0;
            note_on_number = '0;
            expected_msgs.delete();
        end else begin
            // A transaction is taken on the edge where start is high and busy is low.
            if (i_start && !i_busy) begin
                if (i_func == FUNC_TICK)
                    play_tick();
                else if (i_note_number < NOTE_SLOTS)
                    held_vel[i_note_number] = i_note_velocity;
            end
            if ($isunknown(i_strobe)) begin
                mismatch_count++;
                $display("%0t: strobe mismatch, expected 0 or 1, actual %b",
                         $time, i_strobe);
            end else if (i_strobe) begin
                message_count++;
                if (expected_msgs.size() == 0) begin
                    mismatch_count++;
                    $display({"%0t: message mismatch, expected none, ",
                              "actual note %0d vel %0d bang %b last %b"},
                             $time, i_out_note, i_out_velocity, i_bang, i_last);
                end else begin
                    want = expected_msgs.pop_front();
                    check_field("out_note", 8'(want.note), 8'(i_out_note));
                    check_field("out_velocity", 8'(want.vel), 8'(i_out_velocity));
                    check_field("bang", 8'(want.bang), 8'(i_bang));
                    check_field("last", 8'(want.last), 8'(i_last));
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_msgs.size();
        o_messages   <= message_count;
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Top of the up arpeggiator testbench: clock, reset, note and tick stimulus, and the verdict.
// Depends on ua_pkg, up_arpeggiator and arp_step_checker.
module testbench;
    import ua_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CALM_ITEMS   = 300;
    localparam int PHASE_ITEMS  = 150;
    localparam int TICK_CYCLES  = 2 * NOTE_SLOTS + 3;
    localparam int DRAIN_CYCLES = 4 * TICK_CYCLES;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_func = FUNC_NOTE;
    logic [NOTE_W-1:0] i_note_number = '0;
    logic [VEL_W-1:0]  i_note_velocity = '0;
    logic              o_strobe;
    logic [NOTE_W-1:0] o_out_note;
    logic [VEL_W-1:0]  o_out_velocity;
    logic              o_bang;
    logic              o_last;

    int                mismatches;
    int                pending;
    int                messages;
    int                cycle_count = 0;
    int                note_events = 0;
    int                tick_events = 0;
    bit                gaps_on = 1'b0;
    int                gap_pct = 0;
    logic [NOTE_W-1:0] pressed [$];

    always #6 i_clk = ~i_clk;

    up_arpeggiator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_note_number   (i_note_number),
        .i_note_velocity (i_note_velocity),
        .o_strobe        (o_strobe),
        .o_out_note      (o_out_note),
        .o_out_velocity  (o_out_velocity),
        .o_bang          (o_bang),
        .o_last          (o_last)
    );

    arp_step_checker step_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (i_func),
        .i_note_number   (i_note_number),
        .i_note_velocity (i_note_velocity),
        .i_strobe        (o_strobe),
        .i_out_note      (o_out_note),
        .i_out_velocity  (o_out_velocity),
        .i_bang          (o_bang),
        .i_last          (o_last),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_messages      (messages)
    );

    // Presents one transaction and returns on the edge that accepts it.
    task automatic issue(logic func, logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
        if (gaps_on && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_func          <= func;
        i_note_number   <= note;
        i_note_velocity <= vel;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (func == FUNC_TICK)
            tick_events++;
        else
            note_events++;
    endtask

    initial begin : stimulus
        int                pick;
        int                chord_cap;
        int                idx;
        logic [NOTE_W-1:0] nn;
        logic [VEL_W-1:0]  vv;
        chord_cap = 4;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty table, the pitch extremes, release of the
        // sounding note, the final note-off and a stale step index.
        issue(FUNC_TICK, 7'h7F, 7'h7F);
        issue(FUNC_NOTE, 7'd0, 7'd127);
        issue(FUNC_NOTE, 7'd127, 7'd1);
        issue(FUNC_NOTE, 7'd64, 7'h2A);
        issue(FUNC_TICK, 7'h00, 7'h00);
        issue(FUNC_TICK, 7'h55, 7'h2A);
        issue(FUNC_TICK, 7'h2A, 7'h55);
        issue(FUNC_NOTE, 7'd0, 7'd0);
        issue(FUNC_TICK, 7'h7F, 7'h00);
        issue(FUNC_NOTE, 7'd127, 7'd0);
        issue(FUNC_NOTE, 7'd64, 7'd0);
        issue(FUNC_TICK, 7'h00, 7'h7F);
        issue(FUNC_TICK, 7'h11, 7'h22);
        issue(FUNC_NOTE, 7'd5, 7'h55);
        issue(FUNC_NOTE, 7'd9, 7'd100);
        issue(FUNC_NOTE, 7'd12, 7'd33);
        issue(FUNC_NOTE, 7'd20, 7'd2);
        issue(FUNC_TICK, 7'h33, 7'h44);
        issue(FUNC_TICK, 7'h66, 7'h01);
        issue(FUNC_TICK, 7'h40, 7'h3F);
        issue(FUNC_NOTE, 7'd20, 7'd0);
        issue(FUNC_NOTE, 7'd12, 7'd0);
        issue(FUNC_TICK, 7'h01, 7'h40);
        issue(FUNC_NOTE, 7'd3, 7'd0);
        issue(FUNC_TICK, 7'h7E, 7'h7E);
        pressed = '{7'd5, 7'd9};

        // Random part: chords of varying size built up and released between
        // ticks, with a little noise on the note events.
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % PHASE_ITEMS == 0) begin
                case ($urandom_range(7))
                    0: chord_cap = 0;
                    1: chord_cap = 1;
                    2: chord_cap = 2;
                    3: chord_cap = 3;
                    4: chord_cap = 5;
                    5: chord_cap = 10;
                    6: chord_cap = 30;
                    default: chord_cap = NOTE_SLOTS;
                endcase
                gap_pct = 25 * $urandom_range(2);
            end
            gaps_on = (item < RANDOM_ITEMS - CALM_ITEMS);
            pick = $urandom_range(99);
            if (pick < 35 && pressed.size() < chord_cap) begin
                nn = NOTE_W'($urandom);
                vv = VEL_W'($urandom_range(1, 127));
                issue(FUNC_NOTE, nn, vv);
                pressed = {pressed, nn};
            end else if (pick < 60 && pressed.size() != 0) begin
                idx = $urandom_range(pressed.size() - 1);
                issue(FUNC_NOTE, pressed[idx], '0);
                pressed.delete(idx);
            end else if (pick < 65) begin
                nn = NOTE_W'($urandom);
                vv = VEL_W'($urandom);
                issue(FUNC_NOTE, nn, vv);
                if (vv != '0)
                    pressed = {pressed, nn};
            end else begin
                issue(FUNC_TICK, NOTE_W'($urandom), VEL_W'($urandom));
            end
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d note events and %0d ticks accepted, %0d messages checked",
                 note_events, tick_events, messages);
        if (mismatches == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d messages still expected", cycle_count, pending);
        $display("testbench: errors");
        $finish;
    end

endmodule
